// ===== src/fsa_pkg.sv =====
package fsa_pkg;

    // Default number of clip slots.
    localparam int DefClipSlots = 4;

    // Fixed-point constants.
    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam logic [2:0]  NO_CLIP     = 3'd7;
    localparam logic [19:0] MIN_FADE    = 20'd7;
    localparam logic [20:0] ELAPSED_MAX = 21'h1FFFFF;

    // Register indexes beyond the four clip slots.
    localparam logic [2:0] REG_CLIP_COUNT = 3'd4;
    localparam logic [2:0] REG_MESH_TOTAL = 3'd5;

    // Divider step counts for the wrap and the fade weight.
    localparam logic [4:0] MOD_STEPS = 5'd20;
    localparam logic [4:0] DIV_STEPS = 5'd16;

    // Command codes.
    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_PLAY   = 3'd1,
        CMD_SET    = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_RESUME = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_STEP,
        ST_MOD,
        ST_WRAP,
        ST_FADE,
        ST_DIV,
        ST_DONE
    } state_t;

    // Saturate a wide signed position to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -36'sh0_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/frame_sequence_animator_core.sv =====
// Sequence: a playing tick runs multiply and step, then, when looping, the 20-step wrap
// remainder and the wrap, then fade and, during a cross-fade, the 16-step fade weight; both
// divisions share one restoring divider. A playing tick with no clip and no mesh frames
// goes from step to done; a paused tick and other commands go from idle straight to done.
// Throughput: one item at a time; s_tready is high only while idle.
// Reset: synchronous active-low aresetn clears config, animation state and sequencer; no clip, weight one.
module frame_sequence_animator_core #(
    parameter int CLIP_SLOTS = fsa_pkg::DefClipSlots
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [48:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // delta_time[19:0], clip_select[21:20], restart_flag[22],
    // fade_length[42:23], new_position[74:43], zero fill
    input  logic [79:0]  s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accepted[0], mesh_update[1], frame_position[33:2], range_valid[34],
    // range_start[50:35], range_end[66:51], blend_active[67],
    // old_position[99:68], old_start[115:100], old_end[131:116],
    // blend_weight[148:132], running[149], zero fill
    output logic [151:0] m_tdata
);
    import fsa_pkg::*;

    // Configuration registers.
    logic [48:0] slot_reg [CLIP_SLOTS];
    logic [2:0]  count_reg;
    logic [15:0] mesh_total_reg;

    // Animation state.
    logic [2:0]         cur_clip_reg, prev_clip_reg;
    logic signed [31:0] pos_reg, frozen_reg;
    logic signed [15:0] rate_reg;
    logic               loop_reg, playing_reg, blending_reg;
    logic [20:0]        elapsed_reg;
    logic [19:0]        ftotal_reg;
    logic [16:0]        alpha_reg;

    // Sequencer and work registers.
    state_t             state_reg, state_next;
    logic [19:0]        dt_reg;
    logic signed [36:0] prod_reg;
    logic               acc_reg, upd_reg, end_pend_reg;
    logic               neg_reg;
    logic [15:0]        frac_reg, wlo_reg;
    logic [19:0]        rem_reg, dvd_reg, dsr_reg;
    logic [14:0]        quot_reg;
    logic [4:0]         cnt_reg;
    logic [151:0]       out_reg;
    logic               out_valid_reg;

    // Read one clip slot.
    function automatic logic [48:0] slot_rd(input logic [2:0] c);
        logic [48:0] v;
        v = '0;
        for (int i = 0; i < CLIP_SLOTS; i++) begin
            if (c == 3'(i)) v = slot_reg[i];
        end
        return v;
    endfunction

    // A clip index is valid below both the slot count and clip_count.
    function automatic logic clip_ok(input logic [2:0] c);
        return (32'(c) < CLIP_SLOTS) && (c < count_reg);
    endfunction

    // Input fields.
    cmd_t               in_cmd;
    logic [19:0]        in_dt, in_fade;
    logic [1:0]         in_sel;
    logic               in_restart;
    logic [31:0]        in_pos;
    assign in_cmd     = cmd_t'(s_tuser);
    assign in_dt      = s_tdata[19:0];
    assign in_sel     = s_tdata[21:20];
    assign in_restart = s_tdata[22];
    assign in_fade    = s_tdata[42:23];
    assign in_pos     = s_tdata[74:43];

    logic in_xfer;
    assign in_xfer = s_tvalid && s_tready;

    // Current and previous clip fields.
    logic [48:0] cur_slot, prev_slot, sel_slot;
    logic        cur_ok, prev_ok, blend_ok, sel_ok, changing;
    logic [15:0] cur_lo, cur_hi;
    assign cur_slot  = slot_rd(cur_clip_reg);
    assign prev_slot = slot_rd(prev_clip_reg);
    assign sel_slot  = slot_rd({1'b0, in_sel});
    assign cur_ok    = clip_ok(cur_clip_reg);
    assign prev_ok   = clip_ok(prev_clip_reg);
    assign blend_ok  = blending_reg && prev_ok;
    assign sel_ok    = clip_ok({1'b0, in_sel});
    assign changing  = (cur_clip_reg != NO_CLIP) && (cur_clip_reg != {1'b0, in_sel});
    assign cur_lo    = (cur_slot[15:0] < cur_slot[31:16]) ? cur_slot[15:0] : cur_slot[31:16];
    assign cur_hi    = (cur_slot[15:0] < cur_slot[31:16]) ? cur_slot[31:16] : cur_slot[15:0];

    // Step and candidate position.
    logic signed [36:0] prod_round;
    logic signed [28:0] step;
    logic signed [35:0] f_wide, x_wide, clamp_lim;
    logic signed [19:0] x_hi;
    logic               clamp_hit;
    assign prod_round = prod_reg + 37'sd128;
    assign step       = prod_round[36:8];
    assign f_wide     = {{4{pos_reg[31]}}, pos_reg} + {{7{step[28]}}, step};
    assign x_wide     = cur_ok ? (f_wide - $signed({4'b0, cur_lo, 16'b0})) : f_wide;
    assign x_hi       = x_wide[35:16];
    assign clamp_lim  = cur_ok ? $signed({4'b0, cur_hi, 16'b0})
                               : $signed({4'b0, mesh_total_reg - 16'd1, 16'b0});
    assign clamp_hit  = f_wide > clamp_lim;

    // Shared restoring divider step.
    logic [20:0] trial;
    logic        trial_ge;
    logic [19:0] rem_step;
    assign trial    = {rem_reg, dvd_reg[19]};
    assign trial_ge = trial >= {1'b0, dsr_reg};
    assign rem_step = trial_ge ? 20'(trial - {1'b0, dsr_reg}) : trial[19:0];

    // Wrap correction for negative offsets.
    logic [16:0] wrap_r;
    logic [15:0] wrap_frame;
    assign wrap_r     = (neg_reg && (rem_reg != 20'd0)) ? 17'(dsr_reg - rem_reg) : rem_reg[16:0];
    assign wrap_frame = wlo_reg + wrap_r[15:0];

    // Fade elapsed time and weight divisor.
    logic [21:0] el_sum;
    logic [20:0] el_sat;
    logic [19:0] fade_div;
    assign el_sum   = {1'b0, elapsed_reg} + {2'b0, dt_reg};
    assign el_sat   = (el_sum > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : el_sum[20:0];
    assign fade_div = (ftotal_reg > MIN_FADE) ? ftotal_reg : MIN_FADE;

    logic out_load;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = (in_cmd == CMD_TICK && playing_reg) ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:  state_next = ST_STEP;
            ST_STEP: begin
                if (!cur_ok && mesh_total_reg == 16'd0) begin
                    state_next = ST_DONE;
                end else if (loop_reg) begin
                    state_next = ST_MOD;
                end else begin
                    state_next = ST_FADE;
                end
            end
            ST_MOD:  state_next = (cnt_reg == 5'd1) ? ST_WRAP : ST_MOD;
            ST_WRAP: state_next = ST_FADE;
            ST_FADE: begin
                if (cur_ok && blend_ok && el_sat < {1'b0, fade_div}) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:  state_next = (cnt_reg == 5'd1) ? ST_DONE : ST_DIV;
            ST_DONE: state_next = out_load ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = out_valid_reg;
        m_tdata  = out_reg;
    end

    // Sequencer state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CLIP_SLOTS; i++) slot_reg[i] <= '0;
            count_reg      <= '0;
            mesh_total_reg <= '0;
        end else if (cfg_we) begin
            for (int i = 0; i < CLIP_SLOTS; i++) begin
                if (cfg_index == 3'(i)) slot_reg[i] <= cfg_data;
            end
            if (cfg_index == REG_CLIP_COUNT) count_reg <= cfg_data[2:0];
            if (cfg_index == REG_MESH_TOTAL) mesh_total_reg <= cfg_data[15:0];
        end
    end

    // Animation state and datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_clip_reg  <= NO_CLIP;
            prev_clip_reg <= NO_CLIP;
            pos_reg       <= '0;
            frozen_reg    <= '0;
            rate_reg      <= '0;
            loop_reg      <= 1'b0;
            playing_reg   <= 1'b0;
            blending_reg  <= 1'b0;
            elapsed_reg   <= '0;
            ftotal_reg    <= '0;
            alpha_reg     <= ONE_Q16;
            acc_reg       <= 1'b0;
            upd_reg       <= 1'b0;
            end_pend_reg  <= 1'b0;
        end else begin
            unique case (state_reg) inside
                ST_IDLE: begin
                    if (in_xfer) begin
                        // Only a play with an invalid index is refused.
                        acc_reg      <= !(in_cmd == CMD_PLAY && !sel_ok);
                        upd_reg      <= (in_cmd == CMD_TICK && playing_reg)
                                     || (in_cmd == CMD_PLAY && sel_ok)
                                     || (in_cmd == CMD_SET);
                        end_pend_reg <= 1'b0;
                        dt_reg       <= in_dt;
                        case (in_cmd)
                            CMD_PLAY: begin
                                if (sel_ok) begin
                                    if (changing && in_fade != 20'd0) begin
                                        prev_clip_reg <= cur_clip_reg;
                                        frozen_reg    <= pos_reg;
                                        blending_reg  <= 1'b1;
                                        elapsed_reg   <= '0;
                                        ftotal_reg    <= in_fade;
                                        alpha_reg     <= '0;
                                    end else begin
                                        prev_clip_reg <= NO_CLIP;
                                        blending_reg  <= 1'b0;
                                        elapsed_reg   <= '0;
                                        ftotal_reg    <= '0;
                                        alpha_reg     <= ONE_Q16;
                                    end
                                    cur_clip_reg <= {1'b0, in_sel};
                                    rate_reg     <= sel_slot[47:32];
                                    loop_reg     <= sel_slot[48];
                                    playing_reg  <= 1'b1;
                                    if (in_restart || changing) begin
                                        pos_reg <= sel_slot[15] ? 32'sh7FFF_FFFF
                                                                : {sel_slot[15:0], 16'b0};
                                    end
                                end
                            end
                            CMD_SET: begin
                                pos_reg       <= in_pos;
                                prev_clip_reg <= NO_CLIP;
                                blending_reg  <= 1'b0;
                                elapsed_reg   <= '0;
                                ftotal_reg    <= '0;
                                alpha_reg     <= ONE_Q16;
                            end
                            CMD_STOP:   playing_reg <= 1'b0;
                            CMD_RESUME: playing_reg <= 1'b1;
                            CMD_CLEAR: begin
                                cur_clip_reg  <= NO_CLIP;
                                prev_clip_reg <= NO_CLIP;
                                blending_reg  <= 1'b0;
                                elapsed_reg   <= '0;
                                ftotal_reg    <= '0;
                                alpha_reg     <= ONE_Q16;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL: begin
                    prod_reg <= $signed({17'b0, dt_reg}) * rate_reg;
                end
                ST_STEP: begin
                    // Without frames drop the update; else set up the wrap remainder, or clamp or store.
                    if (!cur_ok && mesh_total_reg == 16'd0) begin
                        upd_reg <= 1'b0;
                    end else if (loop_reg) begin
                        neg_reg  <= x_hi[19];
                        frac_reg <= x_wide[15:0];
                        wlo_reg  <= cur_ok ? cur_lo : 16'd0;
                        rem_reg  <= '0;
                        dvd_reg  <= x_hi[19] ? 20'(-x_hi) : x_hi;
                        dsr_reg  <= cur_ok ? 20'(17'(cur_hi) - 17'(cur_lo) + 17'd1)
                                           : {4'b0, mesh_total_reg};
                        cnt_reg  <= MOD_STEPS;
                    end else if (clamp_hit) begin
                        pos_reg     <= sat32(clamp_lim);
                        playing_reg <= 1'b0;
                    end else begin
                        pos_reg <= sat32(f_wide);
                    end
                end
                ST_MOD, ST_DIV: begin
                    rem_reg  <= rem_step;
                    dvd_reg  <= {dvd_reg[18:0], 1'b0};
                    quot_reg <= {quot_reg[13:0], trial_ge};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (state_reg == ST_DIV && cnt_reg == 5'd1) begin
                        alpha_reg <= {1'b0, quot_reg, trial_ge};
                    end
                end
                ST_WRAP: begin
                    pos_reg <= sat32({4'b0, wrap_frame, frac_reg});
                end
                ST_FADE: begin
                    // Advance the cross-fade; a full weight ends it after the result.
                    if (cur_ok && blend_ok) begin
                        elapsed_reg <= el_sat;
                        if (el_sat >= {1'b0, fade_div}) begin
                            alpha_reg    <= ONE_Q16;
                            end_pend_reg <= 1'b1;
                        end else begin
                            rem_reg <= el_sat[19:0];
                            dvd_reg <= '0;
                            dsr_reg <= fade_div;
                            cnt_reg <= DIV_STEPS;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_load && end_pend_reg) begin
                        end_pend_reg  <= 1'b0;
                        prev_clip_reg <= NO_CLIP;
                        blending_reg  <= 1'b0;
                        elapsed_reg   <= '0;
                        ftotal_reg    <= '0;
                        alpha_reg     <= ONE_Q16;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= {2'b0,
                        playing_reg,
                        alpha_reg,
                        blend_ok ? prev_slot[31:16] : 16'd0,
                        blend_ok ? prev_slot[15:0] : 16'd0,
                        blend_ok ? frozen_reg : 32'sd0,
                        blend_ok,
                        cur_ok ? cur_slot[31:16] : 16'd0,
                        cur_ok ? cur_slot[15:0] : 16'd0,
                        cur_ok,
                        pos_reg,
                        upd_reg,
                        acc_reg};
        end
    end

    // The blend weight never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn) alpha_reg <= ONE_Q16)
        else $error("blend weight above one");

    // Without a fade the weight is one and the elapsed time is clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !blending_reg |-> (alpha_reg == ONE_Q16 && elapsed_reg == 21'd0))
        else $error("fade state left over");

    // A rejected play never updates the mesh.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg[0] |-> !out_reg[1])
        else $error("rejected item updates mesh");

    // The wrap remainder pass runs into the wrap correction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MOD |=> (state_reg == ST_MOD || state_reg == ST_WRAP))
        else $error("wrap remainder pass broken");

endmodule

// ===== verif/frame_sequence_animator_core_checker.sv =====
module frame_sequence_animator_core_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [48:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [79:0]  s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [151:0] m_tdata,
    output int           error_count,
    output int           pending_count,
    output int           result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import fsa_pkg::*;

    localparam longint ONE = 65536;

    // Shadow copy of the registers.
    logic [48:0] clip_reg [4];
    logic [2:0]  clip_limit;
    logic [15:0] mesh_total;

    // Shadow copy of the animation state.
    logic [2:0]  cur_clip, prev_clip;
    longint      pos, frozen_pos;
    int          rate;
    bit          loop_on, playing, fading;
    longint      elapsed, fade_len, alpha;

    logic [151:0] frame_queue [$];

    function automatic bit clip_valid(logic [2:0] c);
        return c < 4 && c < clip_limit;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_mod(longint a, longint m);
        longint r;
        r = a % m;
        return (r < 0) ? r + m : r;
    endfunction

    task automatic drop_fade();
        prev_clip = NO_CLIP;
        fading = 0;
        elapsed = 0;
        fade_len = 0;
        alpha = ONE;
    endtask

    // Builds the result word from the present state.
    function automatic logic [151:0] frame_word(bit acc, bit upd);
        logic [151:0] w;
        bit cur, blend;
        cur = clip_valid(cur_clip);
        blend = fading && clip_valid(prev_clip);
        w = '0;
        w[0] = acc;
        w[1] = upd;
        w[33:2] = pos[31:0];
        w[34] = cur;
        if (cur) begin
            w[50:35] = clip_reg[cur_clip[1:0]][15:0];
            w[66:51] = clip_reg[cur_clip[1:0]][31:16];
        end
        w[67] = blend;
        if (blend) begin
            w[99:68] = frozen_pos[31:0];
            w[115:100] = clip_reg[prev_clip[1:0]][15:0];
            w[131:116] = clip_reg[prev_clip[1:0]][31:16];
        end
        w[148:132] = alpha[16:0];
        w[149] = playing;
        return w;
    endfunction

    task automatic advance_tick(longint dt, output logic [151:0] w);
        longint q, step, f, lo, hi, s, e, d, a;
        if (!playing) begin
            w = frame_word(1, 0);
            return;
        end
        q = dt * rate + 128;
        step = (q >= 0) ? q / 256 : -((-q + 255) / 256);
        if (clip_valid(cur_clip)) begin
            s = clip_reg[cur_clip[1:0]][15:0];
            e = clip_reg[cur_clip[1:0]][31:16];
            lo = (s < e) ? s : e;
            hi = (s < e) ? e : s;
            f = pos + step;
            if (loop_on) begin
                f = lo * ONE + floor_mod(f - lo * ONE, (hi - lo + 1) * ONE);
            end else if (f > hi * ONE) begin
                f = hi * ONE;
                playing = 0;
            end
            pos = clamp32(f);
            if (fading && clip_valid(prev_clip)) begin
                elapsed = elapsed + dt;
                if (elapsed > 2097151) elapsed = 2097151;
                d = (fade_len > 7) ? fade_len : 7;
                a = elapsed * ONE / d;
                if (a > ONE) a = ONE;
                alpha = a;
                w = frame_word(1, 1);
                if (a >= ONE) drop_fade();
                return;
            end
            w = frame_word(1, 1);
            return;
        end
        if (mesh_total == 0) begin
            w = frame_word(1, 0);
            return;
        end
        f = pos + step;
        if (loop_on) begin
            f = floor_mod(f, longint'(mesh_total) * ONE);
        end else if (f > (longint'(mesh_total) - 1) * ONE) begin
            f = (longint'(mesh_total) - 1) * ONE;
            playing = 0;
        end
        pos = clamp32(f);
        w = frame_word(1, 1);
    endtask

    task automatic start_clip(logic [1:0] idx, bit restart, longint fade,
                              output logic [151:0] w);
        bit changing;
        if (!clip_valid({1'b0, idx})) begin
            w = frame_word(0, 0);
            return;
        end
        changing = cur_clip != NO_CLIP && cur_clip != {1'b0, idx};
        if (changing && fade > 0) begin
            prev_clip = cur_clip;
            frozen_pos = pos;
            fading = 1;
            elapsed = 0;
            fade_len = fade;
            alpha = 0;
        end else begin
            drop_fade();
        end
        cur_clip = {1'b0, idx};
        rate = $signed(clip_reg[idx][47:32]);
        loop_on = clip_reg[idx][48];
        playing = 1;
        if (restart || changing) pos = clamp32(longint'(clip_reg[idx][15:0]) * ONE);
        w = frame_word(1, 1);
    endtask

    task automatic predict_frame(logic [2:0] cmd, logic [79:0] d);
        logic [151:0] w;
        case (cmd)
            CMD_TICK: advance_tick(longint'(d[19:0]), w);
            CMD_PLAY: start_clip(d[21:20], d[22], longint'(d[42:23]), w);
            CMD_SET: begin
                pos = longint'($signed(d[74:43]));
                drop_fade();
                w = frame_word(1, 1);
            end
            CMD_STOP: begin
                playing = 0;
                w = frame_word(1, 0);
            end
            CMD_RESUME: begin
                playing = 1;
                w = frame_word(1, 0);
            end
            CMD_CLEAR: begin
                cur_clip = NO_CLIP;
                drop_fade();
                w = frame_word(1, 0);
            end
            default: w = frame_word(1, 0);
        endcase
        frame_queue.insert(frame_queue.size(), w);
    endtask

    task automatic report_mismatch(string what, logic [151:0] got, logic [151:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Compares one result transfer field by field.
    task automatic check_frame(logic [151:0] got);
        logic [151:0] want;
        if (frame_queue.size() == 0) begin
            report_mismatch("unexpected result", got, '0);
            return;
        end
        want = frame_queue.pop_front();
        if (got[0] !== want[0])
            report_mismatch("accepted", 152'(got[0]), 152'(want[0]));
        if (got[1] !== want[1])
            report_mismatch("mesh_update", 152'(got[1]), 152'(want[1]));
        if (got[33:2] !== want[33:2])
            report_mismatch("frame_position", 152'(got[33:2]), 152'(want[33:2]));
        if (got[34] !== want[34])
            report_mismatch("range_valid", 152'(got[34]), 152'(want[34]));
        if (got[50:35] !== want[50:35])
            report_mismatch("range_start", 152'(got[50:35]), 152'(want[50:35]));
        if (got[66:51] !== want[66:51])
            report_mismatch("range_end", 152'(got[66:51]), 152'(want[66:51]));
        if (got[67] !== want[67])
            report_mismatch("blend_active", 152'(got[67]), 152'(want[67]));
        if (got[99:68] !== want[99:68])
            report_mismatch("old_position", 152'(got[99:68]), 152'(want[99:68]));
        if (got[115:100] !== want[115:100])
            report_mismatch("old_start", 152'(got[115:100]), 152'(want[115:100]));
        if (got[131:116] !== want[131:116])
            report_mismatch("old_end", 152'(got[131:116]), 152'(want[131:116]));
        if (got[148:132] !== want[148:132])
            report_mismatch("blend_weight", 152'(got[148:132]), 152'(want[148:132]));
        if (got[149] !== want[149])
            report_mismatch("running", 152'(got[149]), 152'(want[149]));
    endtask

    // Watches both channels and the register port at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) clip_reg[i] = '0;
            clip_limit = 0;
            mesh_total = 0;
            cur_clip = NO_CLIP;
            pos = 0;
            frozen_pos = 0;
            rate = 0;
            loop_on = 0;
            playing = 0;
            drop_fade();
            frame_queue.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index < REG_CLIP_COUNT) clip_reg[cfg_index[1:0]] = cfg_data;
                else if (cfg_index == REG_CLIP_COUNT) clip_limit = cfg_data[2:0];
                else if (cfg_index == REG_MESH_TOTAL) mesh_total = cfg_data[15:0];
            end
            if (m_tvalid && m_tready) begin
                check_frame(m_tdata);
                result_count++;
            end
            if (s_tvalid && s_tready) predict_frame(s_tuser, s_tdata);
        end
        pending_count = frame_queue.size();
    end

    initial begin
        error_count = 0;
        pending_count = 0;
        result_count = 0;
    end
endmodule

// ===== verif/frame_sequence_animator_core_tb.sv =====
module frame_sequence_animator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fsa_pkg::*;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_we = 0;
    logic [2:0]   cfg_index = '0;
    logic [48:0]  cfg_data = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [151:0] m_tdata;
    int           error_count, pending_count, result_count;
    bit           calm = 0;

    always #5 aclk = ~aclk;

    frame_sequence_animator_core i_dut (.*);

    frame_sequence_animator_core_checker i_checker (.*);

    // Result side stalls in short random bursts, none near the end.
    always @(negedge aclk) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        m_tready <= 1'b1;
    end

    task automatic write_reg(logic [2:0] idx, logic [48:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Waits until the block has answered everything, then lets it settle.
    task automatic drain();
        while (pending_count != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    task automatic send_item(cmd_t cmd, logic [19:0] dt, logic [1:0] sel, bit restart,
                             logic [19:0] fade, logic [31:0] newpos);
        if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) @(negedge aclk);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {5'b0, newpos, fade, restart, sel, dt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [48:0] clip_value(logic [15:0] s, logic [15:0] e,
                                              logic [15:0] r, bit lp);
        return {lp, r, e, s};
    endfunction

    task automatic random_clips();
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 7) == 0)
                write_reg(3'(i), 49'({$urandom, $urandom}));
            else
                write_reg(3'(i), clip_value(16'($urandom_range(0, 40)),
                                            16'($urandom_range(0, 40)),
                                            16'($urandom_range(0, 1023)) - 16'd300,
                                            1'($urandom_range(0, 1))));
        end
    endtask

    // Mostly ticks and plays with random content, some other commands.
    task automatic random_item();
        int k;
        cmd_t cmd;
        logic [19:0] dt, fade;
        k = int'($urandom_range(0, 99));
        if (k < 50) cmd = CMD_TICK;
        else if (k < 72) cmd = CMD_PLAY;
        else if (k < 80) cmd = CMD_SET;
        else if (k < 87) cmd = CMD_STOP;
        else if (k < 94) cmd = CMD_RESUME;
        else if (k < 98) cmd = CMD_CLEAR;
        else cmd = cmd_t'(3'($urandom_range(6, 7)));
        dt = ($urandom_range(0, 15) == 0) ? 20'($urandom) : 20'($urandom_range(0, 8000));
        fade = ($urandom_range(0, 2) == 0) ? 20'd0 :
               ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(1, 40000));
        send_item(cmd, dt, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), fade,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 30 << 16));
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: extremes, each command, mesh mode and stale clips.
        write_reg(3'd0, clip_value(16'd2, 16'd10, 16'h0100, 1'b1));
        write_reg(3'd1, clip_value(16'd20, 16'd5, 16'hFF00, 1'b0));
        write_reg(3'd2, clip_value(16'hFFFF, 16'h8000, 16'h7FFF, 1'b1));
        write_reg(3'd3, clip_value(16'd0, 16'd0, 16'h8000, 1'b0));
        write_reg(REG_CLIP_COUNT, 49'd4);
        write_reg(REG_MESH_TOTAL, 49'd0);
        send_item(CMD_RESUME, 20'd0, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(CMD_TICK, 20'hFFFFF, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(CMD_PLAY, 20'd0, 2'd0, 1'b1, 20'd0, 32'd0);
        send_item(CMD_TICK, 20'h10000, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(CMD_PLAY, 20'd0, 2'd1, 1'b0, 20'h08000, 32'd0);
        send_item(CMD_TICK, 20'h04000, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(CMD_TICK, 20'hFFFFF, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(CMD_PLAY, 20'd0, 2'd2, 1'b1, 20'd1, 32'd0);
        send_item(CMD_TICK, 20'hFFFFF, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(CMD_PLAY, 20'd0, 2'd3, 1'b0, 20'hFFFFF, 32'd0);
        send_item(CMD_TICK, 20'hFFFFF, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(CMD_SET, 20'd0, 2'd0, 1'b0, 20'd0, 32'h8000_0000);
        send_item(CMD_SET, 20'd0, 2'd0, 1'b0, 20'd0, 32'h7FFF_FFFF);
        send_item(CMD_STOP, 20'd0, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(CMD_TICK, 20'd100, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(cmd_t'(3'd6), 20'd0, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(cmd_t'(3'd7), 20'hFFFFF, 2'd3, 1'b1, 20'hFFFFF, 32'hFFFF_FFFF);
        drain();
        write_reg(REG_CLIP_COUNT, 49'd1);
        send_item(CMD_PLAY, 20'd0, 2'd3, 1'b1, 20'd0, 32'd0);
        send_item(CMD_RESUME, 20'd0, 2'd0, 1'b0, 20'd0, 32'd0);
        send_item(CMD_CLEAR, 20'd0, 2'd0, 1'b0, 20'd0, 32'd0);
        drain();
        write_reg(REG_MESH_TOTAL, 49'hFFFF);
        send_item(CMD_TICK, 20'h20000, 2'd0, 1'b0, 20'd0, 32'd0);
        drain();
        write_reg(REG_MESH_TOTAL, 49'd3);
        send_item(CMD_TICK, 20'hFFFFF, 2'd0, 1'b0, 20'd0, 32'd0);
        drain();

        // Random phases with changing register settings.
        for (int phase = 0; phase < 8; phase++) begin
            random_clips();
            write_reg(REG_CLIP_COUNT, 49'((phase == 0) ? 3'd0 : (phase == 1) ? 3'd7 :
                                          3'($urandom_range(0, 4))));
            write_reg(REG_MESH_TOTAL, 49'((phase == 2) ? 16'hFFFF :
                                          16'($urandom_range(0, 50))));
            if (phase == 7) calm = 1;
            for (int i = 0; i < 48; i++) begin
                random_item();
                if (i == 24 && $urandom_range(0, 1)) begin
                    drain();
                    write_reg(REG_CLIP_COUNT, 49'($urandom_range(0, 4)));
                end
            end
            drain();
        end

        $display("Covered %0d results over directed and eight random register phases.",
                 result_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("frame_sequence_animator_core_tb: clean");
        end else begin
            $display("frame_sequence_animator_core_tb: errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("frame_sequence_animator_core_tb: errors");
        $finish;
    end
endmodule
